### rtl/core/gyi_pkg.sv
`default_nettype none
package gyi_pkg;

	// defaults for the top-level parameters
	localparam int ANGLE_BITS_DEF = 16;
	localparam int RATE_BITS_DEF  = 16;

	// fixed-point layout
	localparam int FRAC_BITS = 16;
	localparam int STEP_W    = 15;   // clamped step, signed, |step| <= 16383
	localparam int OUT_W     = 16;
	localparam int COEF_W    = 18;   // gain and decay as signed multiplier operands
	localparam int COUNT_W   = 8;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_FRAMES    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_SPIN_STEP = 3'd4;

	localparam logic [15:0] RATE_GAIN_RST      = 16'd19884;
	localparam logic [13:0] MAX_STEP_RST       = 14'd3651;
	localparam logic [16:0] DECAY_FACTOR_RST   = 17'd65173;
	localparam logic [7:0]  IDLE_FRAMES_RST    = 8'd120;
	localparam logic [11:0] IDLE_SPIN_STEP_RST = 12'd61;

	// axis select
	localparam logic [1:0] AX_PITCH = 2'd0;
	localparam logic [1:0] AX_ROLL  = 2'd1;
	localparam logic [1:0] AX_YAW   = 2'd2;

	typedef struct packed {
		logic [15:0] rate_gain;
		logic [13:0] max_step;
		logic [16:0] decay_factor;
		logic [7:0]  idle_frames;
		logic [11:0] idle_spin_step;
	} cfg_t;

endpackage
`default_nettype wire

### rtl/core/gyi_cfg.sv
`default_nettype none
module gyi_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [gyi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [gyi_pkg::CFG_DATA_W-1:0]  cfg_data,
	output gyi_pkg::cfg_t                        cfg
);

	gyi_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_gain      <= gyi_pkg::RATE_GAIN_RST;
			cfg_q.max_step       <= gyi_pkg::MAX_STEP_RST;
			cfg_q.decay_factor   <= gyi_pkg::DECAY_FACTOR_RST;
			cfg_q.idle_frames    <= gyi_pkg::IDLE_FRAMES_RST;
			cfg_q.idle_spin_step <= gyi_pkg::IDLE_SPIN_STEP_RST;
		end else if (cfg_we) begin
			// indexes past the last register are dropped
			case (cfg_index)
				gyi_pkg::REG_RATE_GAIN:      cfg_q.rate_gain      <= cfg_data[15:0];
				gyi_pkg::REG_MAX_STEP:       cfg_q.max_step       <= cfg_data[13:0];
				gyi_pkg::REG_DECAY_FACTOR:   cfg_q.decay_factor   <= cfg_data[16:0];
				gyi_pkg::REG_IDLE_FRAMES:    cfg_q.idle_frames    <= cfg_data[7:0];
				gyi_pkg::REG_IDLE_SPIN_STEP: cfg_q.idle_spin_step <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### rtl/core/gyi_mul.sv
`default_nettype none
module gyi_mul #(
	parameter int A_W = 17,
	parameter int B_W = 18
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [A_W-1:0]     a,
	input  wire logic signed [B_W-1:0]     b,
	output logic signed [A_W+B_W-1:0]      p
);

	logic signed [A_W+B_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
		end
	end

	assign p = p_q;

endmodule
`default_nettype wire

### rtl/core/gyroscope_placeholder_unused.sv
`default_nettype none
module gyi_out_fmt #(
	parameter int ANGLE_BITS = 16
) (
	input  wire logic signed [ANGLE_BITS-1:0] angle,
	output logic        [15:0]                q
);

	// top 16 bits of the angle, or the angle moved up when it is narrower
	generate
		if (ANGLE_BITS >= 16) begin : g_down
			assign q = angle[ANGLE_BITS-1 -: 16];
		end else begin : g_up
			assign q = {angle, {(16-ANGLE_BITS){1'b0}}};
		end
	endgenerate

endmodule
`default_nettype wire

### rtl/core/gyro_orientation_integrator_top.sv
`default_nettype none
// Gyro orientation integrator. Each accepted input transfer is one frame: the
// three rates are scaled by rate_gain, rounded, clamped to +-max_step, added to
// the pitch/roll/yaw binary angles (one turn = 2^ANGLE_BITS) and scaled by
// decay_factor; after more than idle_frames zero frames pitch and roll only
// decay and yaw advances by idle_spin_step. One signed multiplier is shared by
// all six products, so each axis passes in turn through five steps (gain
// multiply, round/clamp, add, decay multiply, write-back) before the results
// are loaded into the output register once it is free. in_ready is high only
// while no frame is in work; a result waiting in the output register does not
// block the next input transfer. Configuration writes take effect at once and
// are meant to be made while no frame is in work.
module gyro_orientation_integrator_top #(
	parameter int ANGLE_BITS = gyi_pkg::ANGLE_BITS_DEF,
	parameter int RATE_BITS  = gyi_pkg::RATE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [gyi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gyi_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [RATE_BITS-1:0]       rate_pitch,
	input  wire logic signed [RATE_BITS-1:0]       rate_roll,
	input  wire logic signed [RATE_BITS-1:0]       rate_yaw,
	input  wire logic                              gyro_present,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [gyi_pkg::OUT_W-1:0]       pitch_out,
	output logic signed [gyi_pkg::OUT_W-1:0]       roll_out,
	output logic signed [gyi_pkg::OUT_W-1:0]       yaw_out,
	output logic                                   idle_active
);

	localparam int STEP_W  = gyi_pkg::STEP_W;
	localparam int SUM_W   = ((ANGLE_BITS > STEP_W) ? ANGLE_BITS : STEP_W) + 1;
	localparam int MUL_A_W = (RATE_BITS > SUM_W) ? RATE_BITS : SUM_W;
	localparam int MUL_B_W = gyi_pkg::COEF_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int FRAC    = gyi_pkg::FRAC_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_RND  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_MUL2 = 3'd4;
	localparam logic [2:0] S_WB   = 3'd5;
	localparam logic [2:0] S_HOLD = 3'd6;

	gyi_pkg::cfg_t cfg;

	gyi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic [2:0]                         state_q;
	logic [1:0]                         axis_q;
	logic [gyi_pkg::COUNT_W-1:0]        zcount_q;
	logic                               idle_q;
	logic signed [RATE_BITS-1:0]        rate_q [3];
	logic signed [ANGLE_BITS-1:0]       angle_q [3];
	logic signed [STEP_W-1:0]           step_q;
	logic signed [SUM_W-1:0]            sum_q;
	logic                               out_valid_q;
	logic [15:0]                        pitch_q, roll_q, yaw_q;
	logic                               idle_out_q;

	// shared multiplier
	logic                               mul_en;
	logic signed [MUL_A_W-1:0]          mul_a;
	logic signed [MUL_B_W-1:0]          mul_b;
	logic signed [PROD_W-1:0]           prod;

	always_comb begin
		mul_en = (state_q == S_MUL1) || (state_q == S_MUL2);
		if (state_q == S_MUL2) begin
			mul_a = MUL_A_W'(sum_q);
			mul_b = MUL_B_W'({1'b0, cfg.decay_factor});
		end else begin
			mul_a = MUL_A_W'(rate_q[axis_q]);
			mul_b = MUL_B_W'({2'b00, cfg.rate_gain});
		end
	end

	gyi_mul #(
		.A_W (MUL_A_W),
		.B_W (MUL_B_W)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// round half away from zero: negative products take a bias one short
	logic signed [PROD_W-1:0] rnd_bias, rnd_sum, rnd, lim, neg_lim, clamped;
	// truncate toward zero: negative products take a bias of 2^FRAC - 1
	logic signed [PROD_W-1:0] trn_bias, trn_sum, trn;

	always_comb begin
		rnd_bias = prod[PROD_W-1] ? PROD_W'((1 << (FRAC-1)) - 1) : PROD_W'(1 << (FRAC-1));
		rnd_sum  = prod + rnd_bias;
		rnd      = rnd_sum >>> FRAC;
		lim      = PROD_W'(cfg.max_step);
		neg_lim  = -lim;
		if (rnd > lim) begin
			clamped = lim;
		end else if (rnd < neg_lim) begin
			clamped = neg_lim;
		end else begin
			clamped = rnd;
		end
		trn_bias = prod[PROD_W-1] ? PROD_W'((1 << FRAC) - 1) : '0;
		trn_sum  = prod + trn_bias;
		trn      = trn_sum >>> FRAC;
	end

	// zero-frame count update at the input transfer
	logic                        in_xfer;
	logic                        zero_frame;
	logic [gyi_pkg::COUNT_W-1:0] zcount_next;

	always_comb begin
		in_xfer    = in_valid && in_ready;
		zero_frame = !gyro_present || (rate_pitch == '0 && rate_roll == '0 && rate_yaw == '0);
		if (!zero_frame) begin
			zcount_next = '0;
		end else if (&zcount_q) begin
			zcount_next = zcount_q;
		end else begin
			zcount_next = zcount_q + 1'b1;
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= gyi_pkg::AX_PITCH;
			zcount_q    <= '0;
			idle_q      <= 1'b0;
			out_valid_q <= 1'b0;
			angle_q[0]  <= '0;
			angle_q[1]  <= '0;
			angle_q[2]  <= '0;
		end else begin
			if (state_q == S_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						zcount_q <= zcount_next;
						idle_q   <= zcount_next > cfg.idle_frames;
						axis_q   <= gyi_pkg::AX_PITCH;
						state_q  <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_RND;
				S_RND:  state_q <= S_SUM;
				S_SUM:  state_q <= S_MUL2;
				S_MUL2: state_q <= S_WB;
				S_WB: begin
					if (idle_q && axis_q == gyi_pkg::AX_YAW) begin
						angle_q[axis_q] <= angle_q[axis_q] + ANGLE_BITS'(cfg.idle_spin_step);
					end else begin
						angle_q[axis_q] <= trn[ANGLE_BITS-1:0];
					end
					if (axis_q == gyi_pkg::AX_YAW) begin
						state_q <= S_HOLD;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= S_MUL1;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	logic [15:0] pitch_fmt, roll_fmt, yaw_fmt;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rate_q[0] <= rate_pitch;
			rate_q[1] <= rate_roll;
			rate_q[2] <= rate_yaw;
		end
		if (state_q == S_RND) begin
			step_q <= idle_q ? '0 : STEP_W'(clamped);
		end
		if (state_q == S_SUM) begin
			sum_q <= SUM_W'(angle_q[axis_q]) + SUM_W'(step_q);
		end
		if (state_q == S_HOLD && out_free) begin
			pitch_q    <= pitch_fmt;
			roll_q     <= roll_fmt;
			yaw_q      <= yaw_fmt;
			idle_out_q <= idle_q;
		end
	end

	gyi_out_fmt #(.ANGLE_BITS(ANGLE_BITS)) u_fmt_pitch (.angle(angle_q[0]), .q(pitch_fmt));
	gyi_out_fmt #(.ANGLE_BITS(ANGLE_BITS)) u_fmt_roll  (.angle(angle_q[1]), .q(roll_fmt));
	gyi_out_fmt #(.ANGLE_BITS(ANGLE_BITS)) u_fmt_yaw   (.angle(angle_q[2]), .q(yaw_fmt));

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign pitch_out   = pitch_q;
	assign roll_out    = roll_q;
	assign yaw_out     = yaw_q;
	assign idle_active = idle_out_q;

endmodule
`default_nettype wire
